// ===== rtl/assert_macros.svh =====
// Assertion macros shared by fgwd_ctrl and fgwd_dp.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/fgwd_pkg.sv =====
// ----------------------------------------------------------------------------
// fgwd_pkg
// Types and constants shared by the wall distance controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fgwd_pkg;

    localparam int NORM_FRAC = 14;
    localparam int MUL_W     = 33;
    localparam int CNT_W     = 5;
    localparam int G_W       = 31;
    localparam int DIV_STEPS = 31;
    localparam int SQ_STEPS  = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AREA,
        S_MCAP,
        S_TLO,
        S_THI,
        S_ACC,
        S_DIV_INIT,
        S_DIV_STEP,
        S_SQ,
        S_GACC,
        S_RAD,
        S_SQRT_INIT,
        S_SQRT_STEP,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_AREA,
        MUL_LO,
        MUL_HI,
        MUL_G
    } t_mul_op;

    typedef struct packed {
        logic        load_in;
        t_mul_op     mul_op;
        logic [1:0]  comp;
        logic        cap_m;
        logic        lo_cap;
        logic        acc_en;
        logic [1:0]  acc_comp;
        logic        gsq_clr;
        logic        div_init;
        logic        div_step;
        logic        gacc;
        logic        rad;
        logic        sqrt_init;
        logic        sqrt_sel;
        logic        sqrt_step;
        logic        root_cap;
        logic        out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic div_sat;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/fgwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fgwd_ctrl
// Sequencer: face accumulation, per-component divide, squares, two roots.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fgwd_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  fgwd_pkg::t_sts i_sts,
    output fgwd_pkg::t_cmd o_cmd
);
    import fgwd_pkg::*;

    t_state           r_state, n_state;
    logic [1:0]       r_k, n_k;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_pass  = r_pass;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_AREA;
            end
            S_AREA: n_state = S_MCAP;
            S_MCAP: begin
                n_k     = '0;
                n_state = S_TLO;
            end
            S_TLO: n_state = S_THI;
            S_THI: begin
                if (r_k == 2'd2) begin
                    n_state = S_ACC;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_TLO;
                end
            end
            S_ACC: begin
                n_k     = '0;
                n_state = i_sts.last ? S_DIV_INIT : S_IDLE;
            end
            S_DIV_INIT: begin
                n_cnt   = CNT_W'(DIV_STEPS - 1);
                n_state = i_sts.div_sat ? S_SQ : S_DIV_STEP;
            end
            S_DIV_STEP: begin
                if (r_cnt == '0) n_state = S_SQ;
                else n_cnt = r_cnt - 1'b1;
            end
            S_SQ: n_state = S_GACC;
            S_GACC: begin
                if (r_k == 2'd2) begin
                    n_state = S_RAD;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_RAD: begin
                n_pass  = 1'b0;
                n_state = S_SQRT_INIT;
            end
            S_SQRT_INIT: begin
                n_cnt   = CNT_W'(SQ_STEPS - 1);
                n_state = S_SQRT_STEP;
            end
            S_SQRT_STEP: begin
                if (r_cnt == '0) begin
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_state = S_SQRT_INIT;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_cmd.mul_op = MUL_NONE;
        o_cmd.comp   = r_k;
        case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.load_in = i_valid;
            end
            S_AREA: o_cmd.mul_op = MUL_AREA;
            S_MCAP: o_cmd.cap_m = 1'b1;
            S_TLO: begin
                o_cmd.mul_op   = MUL_LO;
                o_cmd.acc_en   = (r_k != 2'd0);
                o_cmd.acc_comp = r_k - 2'd1;
            end
            S_THI: begin
                o_cmd.mul_op = MUL_HI;
                o_cmd.lo_cap = 1'b1;
            end
            S_ACC: begin
                o_cmd.acc_en   = 1'b1;
                o_cmd.acc_comp = 2'd2;
                o_cmd.gsq_clr  = 1'b1;
            end
            S_DIV_INIT: o_cmd.div_init = 1'b1;
            S_DIV_STEP: o_cmd.div_step = 1'b1;
            S_SQ:       o_cmd.mul_op   = MUL_G;
            S_GACC:     o_cmd.gacc     = 1'b1;
            S_RAD:      o_cmd.rad      = 1'b1;
            S_SQRT_INIT: begin
                o_cmd.sqrt_init = 1'b1;
                o_cmd.sqrt_sel  = r_pass;
            end
            S_SQRT_STEP: begin
                o_cmd.sqrt_step = 1'b1;
                o_cmd.root_cap  = (r_cnt == '0) && !r_pass;
            end
            S_OUT: o_cmd.out_load = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

    `ASSERT_PROP(a_accept_starts, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_state == S_AREA), "transfer did not start a face")
    `ASSERT_NEVER(a_load_busy, i_clk, i_rst_n, o_cmd.out_load && i_sts.out_busy, "result loaded over a pending one")
    `ASSERT_PROP(a_k_range, i_clk, i_rst_n, (r_state != S_IDLE) |-> (r_k != 2'd3), "component index out of range")

endmodule

`default_nettype wire

// ===== rtl/fgwd_dp.sv =====
// ----------------------------------------------------------------------------
// fgwd_dp
// Datapath: shared multiplier, saturating sums, radix-2 divider, bitwise root.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fgwd_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  fgwd_pkg::t_cmd       i_cmd,
    output fgwd_pkg::t_sts       o_sts,
    input  wire  [31:0]          i_face_area,
    input  wire                  i_face_orientation,
    input  wire  signed [15:0]   i_normal_x,
    input  wire  signed [15:0]   i_normal_y,
    input  wire  signed [15:0]   i_normal_z,
    input  wire  signed [31:0]   i_face_value,
    input  wire  signed [31:0]   i_cell_value,
    input  wire  [31:0]          i_cell_volume,
    input  wire                  i_last_face,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic signed [31:0]   o_distance,
    output logic                 o_negative_radicand
);
    import fgwd_pkg::*;

    localparam int MW  = 64 - FRAC_BITS;       // width of area*|diff| >> FRAC_BITS
    localparam int MS  = (MW + 1) / 2;         // low split of that value
    localparam int NW  = 63 + FRAC_BITS;       // |sum| << FRAC_BITS
    localparam int HW  = NW - G_W;
    localparam int TW  = 2 * MUL_W + MS;
    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;

    // input registers
    logic [31:0]        r_area;
    logic               r_orient;
    logic signed [15:0] r_n [3];
    logic signed [31:0] r_fval, r_cval;
    logic [31:0]        r_vol;
    logic               r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_area   <= i_face_area;
            r_orient <= i_face_orientation;
            r_n[0]   <= i_normal_x;
            r_n[1]   <= i_normal_y;
            r_n[2]   <= i_normal_z;
            r_fval   <= i_face_value;
            r_cval   <= i_cell_value;
            r_vol    <= i_cell_volume;
            r_last   <= i_last_face;
        end
    end

    logic signed [32:0] w_diff;
    logic [32:0]        w_dmag;
    logic [31:0]        w_vol;
    assign w_diff = 33'(r_fval) - 33'(r_cval);
    assign w_dmag = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_vol  = (r_vol == '0) ? 32'd1 : r_vol;

    function automatic logic [16:0] f_nmag(input logic signed [15:0] n);
        logic signed [16:0] e;
        e = 17'(n);
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

    // shared multiplier
    logic [MW-1:0]      r_m;
    logic [30:0]        r_q;
    logic [2*MUL_W-1:0] r_prod, r_plo;
    logic [MUL_W-1:0]   w_ma, w_mb;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.mul_op)
            MUL_AREA: begin
                w_ma = MUL_W'(r_area);
                w_mb = w_dmag;
            end
            MUL_LO: begin
                w_ma = MUL_W'(r_m[MS-1:0]);
                w_mb = MUL_W'(f_nmag(r_n[i_cmd.comp]));
            end
            MUL_HI: begin
                w_ma = MUL_W'(r_m[MW-1:MS]);
                w_mb = MUL_W'(f_nmag(r_n[i_cmd.comp]));
            end
            MUL_G: begin
                w_ma = MUL_W'(r_q);
                w_mb = MUL_W'(r_q);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_op != MUL_NONE) r_prod <= w_ma * w_mb;
        if (i_cmd.lo_cap) r_plo <= r_prod;
        if (i_cmd.cap_m)  r_m   <= r_prod[FRAC_BITS +: MW];
    end

    // face term and saturating accumulate
    logic [TW-1:0]      w_tfull;
    logic [63:0]        w_t;
    logic               w_tneg;
    logic signed [64:0] w_term, w_acc;
    logic signed [63:0] r_sum [3];

    assign w_tfull = (TW'(r_prod) << MS) + TW'(r_plo);
    assign w_t     = w_tfull[NORM_FRAC +: 64];
    assign w_tneg  = r_orient ^ w_diff[32] ^ r_n[i_cmd.acc_comp][15];
    assign w_term  = w_tneg ? -$signed({1'b0, w_t}) : $signed({1'b0, w_t});
    assign w_acc   = 65'(r_sum[i_cmd.acc_comp]) + w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_sum[2] <= '0;
        end else if (i_cmd.acc_en) begin
            if (w_acc > SUM_MAX)       r_sum[i_cmd.acc_comp] <= SUM_MAX[63:0];
            else if (w_acc < -SUM_MAX) r_sum[i_cmd.acc_comp] <= -SUM_MAX[63:0];
            else                       r_sum[i_cmd.acc_comp] <= w_acc[63:0];
        end
    end

    // divider: |sum| * 2^FRAC_BITS / volume, one quotient bit a cycle
    logic [63:0]   w_sabs;
    logic [NW-1:0] w_num;
    logic          w_sat;
    logic [31:0]   r_rem;
    logic [30:0]   r_num;
    logic [32:0]   w_rem2;
    logic          w_qbit;

    assign w_sabs = r_sum[i_cmd.comp][63] ? 64'(-r_sum[i_cmd.comp]) : 64'(r_sum[i_cmd.comp]);
    assign w_num  = {w_sabs[62:0], {FRAC_BITS{1'b0}}};
    assign w_sat  = w_num[NW-1:G_W] >= HW'(w_vol);
    assign w_rem2 = {r_rem, r_num[30]};
    assign w_qbit = w_rem2 >= 33'(w_vol);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= w_num[G_W +: 32];
            r_num <= w_num[G_W-1:0];
            r_q   <= w_sat ? '1 : '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? 32'(w_rem2 - 33'(w_vol)) : w_rem2[31:0];
            r_num <= {r_num[29:0], 1'b0};
            r_q   <= {r_q[29:0], w_qbit};
        end
    end

    // sum of squares and radicand
    logic [63:0] r_gsq, r_rad, w_c2;
    logic        r_nrad;
    logic [31:0] w_cmag;

    assign w_cmag = r_cval[31] ? 32'(-33'(r_cval)) : 32'(r_cval);
    assign w_c2   = 64'(w_cmag) << (FRAC_BITS + 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.gsq_clr) r_gsq <= '0;
        else if (i_cmd.gacc) r_gsq <= r_gsq + r_prod[63:0];
        if (i_cmd.rad) begin
            if (!r_cval[31]) begin
                r_rad  <= r_gsq + w_c2;
                r_nrad <= 1'b0;
            end else if (w_c2 > r_gsq) begin
                r_rad  <= '0;
                r_nrad <= 1'b1;
            end else begin
                r_rad  <= r_gsq - w_c2;
                r_nrad <= 1'b0;
            end
        end
    end

    // integer square root, one result bit a cycle
    logic [63:0] r_sq_val;
    logic [33:0] r_sq_rem;
    logic [31:0] r_sq_root, r_root1;
    logic [35:0] w_sq_rem2, w_sq_trial;
    logic        w_sq_ge;

    assign w_sq_rem2  = {r_sq_rem, r_sq_val[63:62]};
    assign w_sq_trial = 36'({r_sq_root, 2'b01});
    assign w_sq_ge    = w_sq_rem2 >= w_sq_trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_sq_val  <= i_cmd.sqrt_sel ? r_gsq : r_rad;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sq_val  <= {r_sq_val[61:0], 2'b00};
            r_sq_rem  <= w_sq_ge ? 34'(w_sq_rem2 - w_sq_trial) : w_sq_rem2[33:0];
            r_sq_root <= {r_sq_root[30:0], w_sq_ge};
        end
        if (i_cmd.root_cap) r_root1 <= {r_sq_root[30:0], w_sq_ge};
    end

    // output register
    logic signed [33:0] w_d;
    logic               r_ovalid;

    assign w_d = $signed({2'b00, r_root1}) - $signed({2'b00, r_sq_root});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            if (w_d > 34'sd2147483647)       o_distance <= 32'sh7FFF_FFFF;
            else if (w_d < -34'sd2147483648) o_distance <= 32'sh8000_0000;
            else                             o_distance <= w_d[31:0];
            o_negative_radicand <= r_nrad;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_sts.last     = r_last;
    assign o_sts.div_sat  = w_sat;
    assign o_sts.out_busy = r_ovalid && !i_ready;

    `ASSERT_PROP(a_div_rem, i_clk, i_rst_n, i_cmd.div_step |-> (r_rem < w_vol), "divider remainder not below volume")
    `ASSERT_PROP(a_sqrt_rem, i_clk, i_rst_n, i_cmd.sqrt_step |-> (r_sq_rem <= {1'b0, r_sq_root, 1'b0}), "root remainder too large")
    `ASSERT_PROP(a_sum_clear, i_clk, i_rst_n, i_cmd.out_load |=> (r_sum[0] == '0 && r_sum[1] == '0 && r_sum[2] == '0), "sums not cleared after result")

endmodule

`default_nettype wire

// ===== rtl/face_gradient_wall_distance_unit.sv =====
// ----------------------------------------------------------------------------
// face_gradient_wall_distance_unit
// Per-face gradient accumulation and wall distance for one cell at a time.
// ----------------------------------------------------------------------------
// One face is taken at a time. An ordinary face passes through accept, area
// product, capture of the scaled product, two 33x33 multiplier passes per
// normal component and a final accumulate. The last face of a cell adds the
// bit-serial divide and the square of each gradient component (a component
// whose gradient saturates skips the divide steps), the radicand, the two
// bit-serial square roots and the load of the result, with the divider and
// root unit producing one bit a cycle. The result sits in an output
// register, so the next cell's faces are taken while it waits to be
// transferred; a new result that finds an earlier one still waiting holds
// the block until that one is transferred.
`default_nettype none

module face_gradient_wall_distance_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [31:0]         i_face_area,
    input  wire                 i_face_orientation,
    input  wire  signed [15:0]  i_normal_x,
    input  wire  signed [15:0]  i_normal_y,
    input  wire  signed [15:0]  i_normal_z,
    input  wire  signed [31:0]  i_face_value,
    input  wire  signed [31:0]  i_cell_value,
    input  wire  [31:0]         i_cell_volume,
    input  wire                 i_last_face,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic signed [31:0]  o_distance,
    output logic                o_negative_radicand
);
    import fgwd_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    fgwd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    fgwd_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_face_area         (i_face_area),
        .i_face_orientation  (i_face_orientation),
        .i_normal_x          (i_normal_x),
        .i_normal_y          (i_normal_y),
        .i_normal_z          (i_normal_z),
        .i_face_value        (i_face_value),
        .i_cell_value        (i_cell_value),
        .i_cell_volume       (i_cell_volume),
        .i_last_face         (i_last_face),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_distance          (o_distance),
        .o_negative_radicand (o_negative_radicand)
    );

endmodule

`default_nettype wire
